>>> rtl/core/blta_pkg.sv
// Shared types, sizes and helper functions for the block luminance to ASCII converter.
// No dependencies. Used by every module under rtl/core.
package blta_pkg;

    // Canvas geometry
    localparam int BYTES_PER_ROW  = 40;
    localparam int ROWS_PER_BLOCK = 6;
    localparam int GRID_ROWS      = 22;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int COL_W   = 6;
    localparam int RIB_W   = 3;
    localparam int ROW_W   = 5;
    localparam int SUM_W   = 7;
    localparam int GLYPH_W = 7;
    localparam int PSUM_W  = 4;

    // Luminance quantization
    localparam int LEVELS    = 10;
    localparam int LEVEL_W   = 4;
    localparam int SUM_MAX   = 12 * ROWS_PER_BLOCK;
    localparam int SCALED_W  = 11;
    localparam int PIX_MASK  = 3;

    typedef logic [GLYPH_W-1:0] glyph_code_t;

    // Glyph ramp, darkest first
    localparam glyph_code_t GLYPHS [LEVELS] = '{
        7'h20, 7'h2E, 7'h3A, 7'h2D, 7'h3D, 7'h2B, 7'h2A, 7'h23, 7'h25, 7'h40
    };

    typedef struct packed {
        logic [PIX_W-1:0] pixel_byte;
        logic             frame_start;
    } in_item_t;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [COL_W-1:0]   glyph_column;
        logic [ROW_W-1:0]   glyph_row;
        logic               frame_done;
    } out_item_t;

    // Raster position of the byte being processed
    typedef struct packed {
        logic [COL_W-1:0] byte_column;
        logic [RIB_W-1:0] row_in_block;
        logic [ROW_W-1:0] block_row;
    } pos_t;

    // Sum of the four 2-bit pixels in a byte
    function automatic logic [PSUM_W-1:0] pixel_sum(input logic [PIX_W-1:0] b);
        logic [PSUM_W-1:0] p0, p1, p2, p3;
        p0 = PSUM_W'(b[7:6] & 2'(PIX_MASK));
        p1 = PSUM_W'(b[5:4] & 2'(PIX_MASK));
        p2 = PSUM_W'(b[3:2] & 2'(PIX_MASK));
        p3 = PSUM_W'(b[1:0] & 2'(PIX_MASK));
        return p0 + p1 + p2 + p3;
    endfunction

    // Block sum to glyph: level = round half up of sum*9/SUM_MAX, clamped.
    // The level counts the multiples of SUM_MAX that the scaled sum reaches,
    // so the top level caps itself.
    function automatic glyph_code_t glyph_of_sum(input logic [SUM_W-1:0] s);
        logic [SCALED_W-1:0] scaled;
        logic [LEVEL_W-1:0]  lvl;
        scaled = SCALED_W'(s) * SCALED_W'(LEVELS - 1) + SCALED_W'(SUM_MAX / 2);
        lvl    = '0;
        for (int k = 1; k < LEVELS; k++) begin
            if (scaled >= SCALED_W'(k * SUM_MAX)) begin
                lvl = lvl + 1'b1;
            end
        end
        return GLYPHS[lvl];
    endfunction

endpackage

>>> rtl/core/blta_cell.sv
// One accumulator cell of the column ring: holds one column's partial block sum.
// Depends on blta_pkg for the sum width.
module blta_cell (
    input  logic                          aclk,
    input  logic                          shift_en,
    input  logic [blta_pkg::SUM_W-1:0]    d,
    output logic [blta_pkg::SUM_W-1:0]    q
);

    logic [blta_pkg::SUM_W-1:0] sum_reg;

    // Take the neighbor's value on every transfer
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            sum_reg <= d;
        end
    end

    assign q = sum_reg;

endmodule

>>> rtl/core/blta_pos.sv
// Raster position counters: byte column, row within block, block row.
// Depends on blta_pkg for geometry constants and pos_t.
module blta_pos (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               frame_start,
    output blta_pkg::pos_t     pos
);

    blta_pkg::pos_t pos_reg;
    blta_pkg::pos_t pos_next;

    // frame_start restarts the frame before the current byte is placed
    assign pos = frame_start ? '0 : pos_reg;

    // Column, then row in block, then block row, each wrapping
    always_comb begin
        pos_next = pos;
        if ({1'b0, pos.byte_column} + 1'b1 >= (blta_pkg::COL_W + 1)'(blta_pkg::BYTES_PER_ROW)) begin
            pos_next.byte_column = '0;
            if ({1'b0, pos.row_in_block} + 1'b1 >=
                (blta_pkg::RIB_W + 1)'(blta_pkg::ROWS_PER_BLOCK)) begin
                pos_next.row_in_block = '0;
                if ({1'b0, pos.block_row} + 1'b1 >=
                    (blta_pkg::ROW_W + 1)'(blta_pkg::GRID_ROWS)) begin
                    pos_next.block_row = '0;
                end else begin
                    pos_next.block_row = pos.block_row + 1'b1;
                end
            end else begin
                pos_next.row_in_block = pos.row_in_block + 1'b1;
            end
        end else begin
            pos_next.byte_column = pos.byte_column + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (advance) begin
            pos_reg <= pos_next;
        end
    end

endmodule

>>> rtl/core/block_luminance_to_ascii.sv
// Top level: packed 2-bpp canvas bytes in, one ASCII glyph out per 4x6-pixel block.
// Depends on blta_pkg, blta_cell and blta_pos.
//
//  channel   direction  ports                       payload
//  -------   ---------  --------------------------  -------------------------------------
//  s_        in         s_valid, s_ready, s_data    pixel_byte, frame_start
//  m_        out        m_valid, m_ready, m_data    glyph, glyph_column, glyph_row, frame_done
//
// One byte is taken per cycle while s_ready is high; the column ring of 40 cells shifts once per transfer,
// so its head always holds the running sum of the column now arriving.
// A glyph appears on m_ after the last-row byte of its block passes stage 1 and the output register.
// Reset clears the counters and pipeline valids only; the ring fills on the first row.
// With m_ready low, one glyph waits in the output register and one more in the sum
// stage; s_ready drops only when both are held.
module block_luminance_to_ascii (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  blta_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output blta_pkg::out_item_t   m_data
);

    localparam int NCELL = blta_pkg::BYTES_PER_ROW;

    logic                          s_xfer;
    blta_pkg::pos_t                pos;
    logic [blta_pkg::SUM_W-1:0]    ring_q [NCELL];
    logic [blta_pkg::SUM_W-1:0]    head_sum;
    logic [blta_pkg::SUM_W-1:0]    new_sum;
    logic                          emit;
    logic                          last_pos;
    logic                          out_load;

    logic                          s1_valid_reg;
    logic [blta_pkg::SUM_W-1:0]    s1_sum_reg;
    logic [blta_pkg::COL_W-1:0]    s1_col_reg;
    logic [blta_pkg::ROW_W-1:0]    s1_row_reg;
    logic                          s1_done_reg;

    logic                          m_valid_reg;
    blta_pkg::out_item_t           m_data_reg;
    blta_pkg::out_item_t           m_data_next;

    // Handshake: stage 1 frees up when empty or when it drains into the output
    assign out_load = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || out_load;
    assign s_xfer   = s_valid && s_ready;

    blta_pos u_pos (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (s_xfer),
        .frame_start (s_data.frame_start),
        .pos         (pos)
    );

    // Accumulate: first row of a block overwrites, later rows add
    assign head_sum = ring_q[NCELL-1];
    assign new_sum  = ((pos.row_in_block == '0) ? '0 : head_sum)
                    + blta_pkg::SUM_W'(blta_pkg::pixel_sum(s_data.pixel_byte));
    assign emit     = (pos.row_in_block == blta_pkg::RIB_W'(blta_pkg::ROWS_PER_BLOCK - 1));
    assign last_pos = (pos.block_row == blta_pkg::ROW_W'(blta_pkg::GRID_ROWS - 1))
                   && (pos.byte_column == blta_pkg::COL_W'(blta_pkg::BYTES_PER_ROW - 1));

    // Column ring: new sum enters cell 0, the oldest leaves at the head
    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                blta_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (s_xfer),
                    .d        (new_sum),
                    .q        (ring_q[gi])
                );
            end else begin : g_rest
                blta_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (s_xfer),
                    .d        (ring_q[gi-1]),
                    .q        (ring_q[gi])
                );
            end
        end
    endgenerate

    // Stage 1: finished block sum and its grid position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            s1_valid_reg <= emit;
        end else if (out_load) begin
            s1_valid_reg <= 1'b0;
        end
        if (s_xfer) begin
            s1_sum_reg  <= new_sum;
            s1_col_reg  <= pos.byte_column;
            s1_row_reg  <= pos.block_row;
            s1_done_reg <= last_pos;
        end
    end

    // Stage 2: quantize to a glyph into the output register
    always_comb begin
        m_data_next.glyph        = blta_pkg::glyph_of_sum(s1_sum_reg);
        m_data_next.glyph_column = s1_col_reg;
        m_data_next.glyph_row    = s1_row_reg;
        m_data_next.frame_done   = s1_done_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // A last-row transfer always leaves a pending result in stage 1
    a_emit_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && emit |=> s1_valid_reg)
        else $error("last-row byte did not produce a pending glyph");

    // Input stalls only when stage 1 holds a result that cannot move
    a_stall_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

    // Frame end flag only at the last grid position
    a_done_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_done |->
            m_data.glyph_column == blta_pkg::COL_W'(blta_pkg::BYTES_PER_ROW - 1) &&
            m_data.glyph_row == blta_pkg::ROW_W'(blta_pkg::GRID_ROWS - 1))
        else $error("frame_done away from the last grid cell");

    // Nothing pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg && !s1_valid_reg)
        else $error("pipeline valid after reset");
`endif

endmodule
